>>> design/cxo_pkg.sv
// Shared types and constants for the AND/XOR cursor overlay.
`default_nettype none

package cxo_pkg;

	// Cursor geometry
	localparam int CURSOR_DIM = 32;
	localparam int DIM_BITS   = $clog2(CURSOR_DIM);

	// Field widths
	localparam int ADDR_W  = 9;
	localparam int COLOR_W = 8;
	localparam int SCR_W   = 11;
	localparam int POS_W   = 12;
	// Offset from window corner: screen position minus signed corner
	localparam int DIFF_W  = POS_W + 1;

	// Image store: AND bytes at even offsets, XOR bytes at odd offsets
	localparam int BANK_AW = ADDR_W - 1;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = POS_W;

	localparam logic [CFG_IDX_W-1:0] CFG_X_POS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_POS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd4;

	localparam logic [COLOR_W-1:0] FG_RESET = 8'h00;
	localparam logic [COLOR_W-1:0] BG_RESET = 8'hff;

	// Item kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [ADDR_W-1:0]  image_addr;
		logic [COLOR_W-1:0] image_data;
		logic [SCR_W-1:0]   screen_x;
		logic [SCR_W-1:0]   screen_y;
		logic [COLOR_W-1:0] frame_pixel;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_out;
		logic               cursor_hit;
	} out_item_t;

	// Window test result handed to the pipeline
	typedef struct packed {
		logic               hit;
		logic [BANK_AW-1:0] word_addr;
		logic [2:0]         bit_sel;
	} lookup_t;

endpackage

`default_nettype wire

>>> design/cxo_bank.sv
// One 256 x 8 bank of the cursor image, single write port, registered read.
`default_nettype none

module cxo_bank
	import cxo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [BANK_AW-1:0] waddr,
	input  wire logic [COLOR_W-1:0] wdata,
	input  wire logic               re,
	input  wire logic [BANK_AW-1:0] raddr,
	output logic      [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [2**BANK_AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/cxo_window.sv
// Window test and image address for one screen pixel.
`default_nettype none

module cxo_window
	import cxo_pkg::*;
(
	input  wire logic             enable,
	input  wire logic [POS_W-1:0] x_pos,
	input  wire logic [POS_W-1:0] y_pos,
	input  wire logic [SCR_W-1:0] screen_x,
	input  wire logic [SCR_W-1:0] screen_y,
	output lookup_t               lookup
);

	logic [DIFF_W-1:0] dx;
	logic [DIFF_W-1:0] dy;
	logic              in_x;
	logic              in_y;

	// Offsets from the signed window corner
	always_comb begin
		dx = {{(DIFF_W-SCR_W){1'b0}}, screen_x} - {x_pos[POS_W-1], x_pos};
		dy = {{(DIFF_W-SCR_W){1'b0}}, screen_y} - {y_pos[POS_W-1], y_pos};
	end

	// 0 <= d < CURSOR_DIM: all bits above the cursor index are zero
	assign in_x = (dx[DIFF_W-1:DIM_BITS] == '0);
	assign in_y = (dy[DIFF_W-1:DIM_BITS] == '0);

	// Row r, group g: word r*8 + g[1]*4 + g[0]; bit 7 is the leftmost pixel
	always_comb begin
		lookup.hit       = enable & in_x & in_y;
		lookup.word_addr = {dy[DIM_BITS-1:0], dx[4], 1'b0, dx[3]};
		lookup.bit_sel   = ~dx[2:0];
	end

endmodule

`default_nettype wire

>>> design/cursor_and_xor_overlay.sv
// Top level: 32x32 AND/XOR cursor overlay on a pixel stream.
// Pipeline: window test and image read in stage 1, colour selection into the
// output register in stage 2. Throughput: one item per cycle while the output
// is not stalled; image writes retire on transfer, no result.
// Reset clears the pipeline valids and sets the registers to their reset values;
// the image store is not cleared and reads as undefined until written.
`default_nettype none

module cursor_and_xor_overlay
	import cxo_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [POS_W-1:0]   x_pos_q;
	logic [POS_W-1:0]   y_pos_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               enable_q;

	logic               in_xfer;
	logic               adv_s1;
	logic               load_s2;
	lookup_t            lookup;

	logic               valid_s1;
	logic               hit_s1;
	logic [2:0]         bit_s1;
	logic [COLOR_W-1:0] pix_s1;
	logic [COLOR_W-1:0] and_s1;
	logic [COLOR_W-1:0] xor_s1;

	logic               out_valid_q;
	out_item_t          out_q;
	logic [COLOR_W-1:0] colour;
	logic               and_bit;
	logic               xor_bit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pos_q  <= '0;
			y_pos_q  <= '0;
			fg_q     <= FG_RESET;
			bg_q     <= BG_RESET;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_POS:  x_pos_q  <= cfg_data;
				CFG_Y_POS:  y_pos_q  <= cfg_data;
				CFG_FG:     fg_q     <= cfg_data[COLOR_W-1:0];
				CFG_BG:     bg_q     <= cfg_data[COLOR_W-1:0];
				CFG_ENABLE: enable_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Flow control
	assign load_s2  = !out_valid_q || out_ready;
	assign adv_s1   = !valid_s1 || load_s2;
	assign in_ready = adv_s1;
	assign in_xfer  = in_valid && in_ready;

	cxo_window u_window (
		.enable   (enable_q),
		.x_pos    (x_pos_q),
		.y_pos    (y_pos_q),
		.screen_x (in_data.screen_x),
		.screen_y (in_data.screen_y),
		.lookup   (lookup)
	);

	// AND plane (even offsets) and XOR plane (odd offsets)
	cxo_bank u_and_bank (
		.clk   (clk),
		.we    (in_xfer && in_data.mode == MODE_WRITE && !in_data.image_addr[0]),
		.waddr (in_data.image_addr[ADDR_W-1:1]),
		.wdata (in_data.image_data),
		.re    (adv_s1),
		.raddr (lookup.word_addr),
		.rdata (and_s1)
	);

	cxo_bank u_xor_bank (
		.clk   (clk),
		.we    (in_xfer && in_data.mode == MODE_WRITE && in_data.image_addr[0]),
		.waddr (in_data.image_addr[ADDR_W-1:1]),
		.wdata (in_data.image_data),
		.re    (adv_s1),
		.raddr (lookup.word_addr),
		.rdata (xor_s1)
	);

	// Stage 1: only pixel items carry on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_xfer && in_data.mode == MODE_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s1 <= lookup.hit;
			bit_s1 <= lookup.bit_sel;
			pix_s1 <= in_data.frame_pixel;
		end
	end

	// Colour selection from the AND/XOR pair
	assign and_bit = and_s1[bit_s1];
	assign xor_bit = xor_s1[bit_s1];

	always_comb begin
		if (!hit_s1) begin
			colour = pix_s1;
		end else if (!and_bit) begin
			colour = xor_bit ? bg_q : fg_q;
		end else begin
			colour = xor_bit ? ~pix_s1 : pix_s1;
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			out_q.pixel_out  <= colour;
			out_q.cursor_hit <= hit_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> design/cxo_checker.sv
// Port-level checks for the cursor overlay, bound to the top level.
`default_nettype none

module cxo_checker
	import cxo_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A free output side never blocks the input
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with output side free");

	// A pixel transfer reaches the output when the output is not stalled behind it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.mode == MODE_PIXEL) ##1 out_ready |=> out_valid)
		else $error("pixel result missing after two cycles");

	// A fresh result always stems from an earlier pixel transfer
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.mode == MODE_PIXEL, 2))
		else $error("result without a pixel transfer");

endmodule

bind cursor_and_xor_overlay cxo_checker u_cxo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
